>>> hw/rtl/bqds_pkg.sv
// Shared types and codes for the bottleneck queue delay scheduler.
`timescale 1ns / 1ps
package bqds_pkg;

	localparam int IDX_BITS = 3;
	localparam int DATA_BITS = 32;
	localparam int NOW_BITS = 48;
	localparam int STORE_BITS = 17;
	localparam int SLOT_BITS = 11;
	localparam int IFACE_BITS = 32;

	localparam logic [IDX_BITS-1:0] CFG_QUEUED_MODE = 3'd0;
	localparam logic [IDX_BITS-1:0] CFG_CROSS_CONNECT = 3'd1;
	localparam logic [IDX_BITS-1:0] CFG_SER_TIME = 3'd2;
	localparam logic [IDX_BITS-1:0] CFG_PROP_DELAY = 3'd3;
	localparam logic [IDX_BITS-1:0] CFG_QUEUE_SLOTS = 3'd4;
	localparam logic [IDX_BITS-1:0] CFG_STORAGE_LIMIT = 3'd5;
	localparam logic [IDX_BITS-1:0] CFG_IFACE_A = 3'd6;
	localparam logic [IDX_BITS-1:0] CFG_IFACE_B = 3'd7;

	localparam logic [1:0] VERDICT_BUFFERED = 2'd0;
	localparam logic [1:0] VERDICT_LOST = 2'd1;
	localparam logic [1:0] VERDICT_FULL = 2'd2;

	typedef struct packed {
		logic                  queued_mode;
		logic                  cross_connect_mode;
		logic [31:0]           ser_time;
		logic [31:0]           propagation_delay;
		logic [SLOT_BITS-1:0]  queue_slots;
		logic [STORE_BITS-1:0] storage_limit;
		logic [IFACE_BITS-1:0] iface_a;
		logic [IFACE_BITS-1:0] iface_b;
	} bqds_cfg_t;

	typedef struct packed {
		logic                  lost;
		logic                  store_full;
		logic [IFACE_BITS-1:0] tx_if;
	} bqds_cls_t;

endpackage

>>> hw/rtl/bqds_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bqds_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> hw/rtl/bqds_front.sv
// Front end: accept packet beats, classify them and buffer them for the back end.
`timescale 1ns / 1ps
module bqds_front #(
	parameter int TIME_BITS = 48
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bqds_pkg::bqds_cfg_t                 cfg,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [bqds_pkg::NOW_BITS-1:0]       now,
	input  logic                                is_lost,
	input  logic [bqds_pkg::STORE_BITS-1:0]     storage_used,
	input  logic [bqds_pkg::IFACE_BITS-1:0]     rx_interface,
	input  logic [bqds_pkg::IFACE_BITS-1:0]     tx_in,
	output logic                                item_valid,
	input  logic                                item_take,
	output logic [TIME_BITS-1:0]                item_now,
	output logic [TIME_BITS-1:0]                item_base,
	output bqds_pkg::bqds_cls_t                 item_cls
);
	import bqds_pkg::*;

	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS:0]   base_sum;
	logic [TIME_BITS-1:0] base_t;
	bqds_cls_t            cls;
	logic                 push;

	logic [TIME_BITS-1:0] now_q [2];
	logic [TIME_BITS-1:0] base_q [2];
	bqds_cls_t            cls_q [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           cnt_q;

	always_comb begin
		now_t = TIME_BITS'(now);
		base_sum = {1'b0, now_t} + (TIME_BITS + 1)'(cfg.propagation_delay);
		base_t = base_sum[TIME_BITS] ? '1 : base_sum[TIME_BITS-1:0];
		cls.lost = is_lost;
		cls.store_full = (storage_used >= cfg.storage_limit);
		if (cfg.cross_connect_mode) begin
			cls.tx_if = (rx_interface == cfg.iface_a) ? cfg.iface_b : cfg.iface_a;
		end else begin
			cls.tx_if = tx_in;
		end
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign item_valid = (cnt_q != 2'd0);
	assign item_now = now_q[rd_ptr_q];
	assign item_base = base_q[rd_ptr_q];
	assign item_cls = cls_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			now_q[wr_ptr_q] <= now_t;
			base_q[wr_ptr_q] <= base_t;
			cls_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (item_take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, item_take})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> hw/rtl/bqds_back.sv
// Back end: drain the departure ring, admit or refuse, schedule and emit result beats.
`timescale 1ns / 1ps
module bqds_back #(
	parameter int QUEUE_DEPTH = 1024,
	parameter int TIME_BITS = 48
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  bqds_pkg::bqds_cfg_t                cfg,
	input  logic                               item_valid,
	output logic                               item_take,
	input  logic [TIME_BITS-1:0]               item_now,
	input  logic [TIME_BITS-1:0]               item_base,
	input  bqds_pkg::bqds_cls_t                item_cls,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [1:0]                         verdict,
	output logic [bqds_pkg::NOW_BITS-1:0]      tx_time,
	output logic [bqds_pkg::IFACE_BITS-1:0]    tx_interface,
	output logic [bqds_pkg::SLOT_BITS-1:0]     queue_depth
);
	import bqds_pkg::*;

	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int MW = (CW > SLOT_BITS) ? CW : SLOT_BITS;

	typedef enum logic [2:0] {
		ST_RD  = 3'b001,
		ST_CMP = 3'b010,
		ST_WR  = 3'b100
	} st_t;

	st_t                  state_q;
	logic [IW-1:0]        head_q;
	logic [IW-1:0]        tail_q;
	logic [CW-1:0]        count_q;
	logic [TIME_BITS-1:0] last_q;
	logic [TIME_BITS-1:0] now_q;
	logic [TIME_BITS-1:0] base_q;
	bqds_cls_t            cls_q;
	logic [TIME_BITS-1:0] dep_q;
	logic                 out_valid_q;

	logic                 rd_en;
	logic [IW-1:0]        rd_addr;
	logic [TIME_BITS-1:0] rd_data;
	logic                 wr_en;
	logic                 out_free;
	logic                 pop;
	logic                 q_full;
	logic                 admit;
	logic                 emit;
	logic [IW-1:0]        head_nx;
	logic [IW-1:0]        tail_nx;
	logic [TIME_BITS-1:0] start_t;
	logic [TIME_BITS:0]   dep_sum;
	logic [TIME_BITS:0]   tx_sum;

	bqds_ram #(
		.WIDTH(TIME_BITS),
		.DEPTH(QUEUE_DEPTH)
	) u_ring (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(tail_q),
		.wr_data(dep_q),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		out_free = !out_valid_q || !out_stall;
		head_nx = (head_q == IW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
		tail_nx = (tail_q == IW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
		pop = cfg.queued_mode && (count_q != '0) && (rd_data <= now_q);
		q_full = cfg.queued_mode && ((MW'(count_q) >= MW'(cfg.queue_slots)) ||
			(MW'(count_q) >= MW'(QUEUE_DEPTH)));
		admit = !cls_q.lost && !cls_q.store_full && !q_full;
		emit = out_free && ((state_q == ST_CMP && !pop && !(admit && cfg.queued_mode)) ||
			(state_q == ST_WR));
		start_t = (now_q > last_q) ? now_q : last_q;
		dep_sum = {1'b0, start_t} + (TIME_BITS + 1)'(cfg.ser_time);
		tx_sum = {1'b0, dep_q} + (TIME_BITS + 1)'(cfg.propagation_delay);
		item_take = (state_q == ST_RD) && item_valid;
		rd_en = 1'b0;
		rd_addr = head_q;
		wr_en = 1'b0;
		unique case (state_q)
			ST_RD: begin
				rd_en = item_valid;
			end
			ST_CMP: begin
				if (pop) begin
					rd_en = 1'b1;
					rd_addr = head_nx;
				end
			end
			ST_WR: begin
				wr_en = out_free;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	always_ff @(posedge clk) begin
		if (item_take) begin
			now_q <= item_now;
			base_q <= item_base;
			cls_q <= item_cls;
		end
		if (state_q == ST_CMP && !pop && admit && cfg.queued_mode) begin
			dep_q <= dep_sum[TIME_BITS] ? '1 : dep_sum[TIME_BITS-1:0];
		end
		if (state_q == ST_CMP && !pop && !(admit && cfg.queued_mode) && out_free) begin
			verdict <= cls_q.lost ? VERDICT_LOST : (admit ? VERDICT_BUFFERED : VERDICT_FULL);
			tx_time <= NOW_BITS'(base_q);
			tx_interface <= admit ? cls_q.tx_if : '0;
			queue_depth <= SLOT_BITS'(count_q);
		end
		if (state_q == ST_WR && out_free) begin
			verdict <= VERDICT_BUFFERED;
			tx_time <= NOW_BITS'(tx_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : tx_sum[TIME_BITS-1:0]);
			tx_interface <= cls_q.tx_if;
			queue_depth <= SLOT_BITS'(count_q + 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RD;
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			last_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_RD: begin
					if (item_valid) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (pop) begin
						head_q <= head_nx;
						count_q <= count_q - 1'b1;
					end else if (admit && cfg.queued_mode) begin
						state_q <= ST_WR;
					end else if (out_free) begin
						state_q <= ST_RD;
					end
				end
				ST_WR: begin
					if (out_free) begin
						tail_q <= tail_nx;
						count_q <= count_q + 1'b1;
						last_q <= dep_q;
						state_q <= ST_RD;
					end
				end
				default: begin
					state_q <= ST_RD;
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/bottleneck_queue_delay_scheduler.sv
// Top level: configuration registers and the front and back ends of the scheduler.
`timescale 1ns / 1ps
// Bottleneck queue delay scheduler. One result beat per packet beat. In the back end
// a packet passes the read and compare states when dropped, refused or sent outside
// queued mode, and the write state too when admitted to the departure ring; each
// expired departure popped first adds a pass through compare (registered RAM read).
// A two-entry queue behind the front end keeps accepting packets while the back end
// works and a result waits in the output register.
module bottleneck_queue_delay_scheduler #(
	parameter int QUEUE_DEPTH = 1024,
	parameter int TIME_BITS = 48
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [bqds_pkg::IDX_BITS-1:0]      cfg_index,
	input  logic [bqds_pkg::DATA_BITS-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [bqds_pkg::NOW_BITS-1:0]      now,
	input  logic                               is_lost,
	input  logic [bqds_pkg::STORE_BITS-1:0]    storage_used,
	input  logic [bqds_pkg::IFACE_BITS-1:0]    rx_interface,
	input  logic [bqds_pkg::IFACE_BITS-1:0]    tx_in,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [1:0]                         verdict,
	output logic [bqds_pkg::NOW_BITS-1:0]      tx_time,
	output logic [bqds_pkg::IFACE_BITS-1:0]    tx_interface,
	output logic [bqds_pkg::SLOT_BITS-1:0]     queue_depth
);
	import bqds_pkg::*;

	bqds_cfg_t            cfg_q;
	logic                 item_valid;
	logic                 item_take;
	logic [TIME_BITS-1:0] item_now;
	logic [TIME_BITS-1:0] item_base;
	bqds_cls_t            item_cls;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.queued_mode <= 1'b0;
			cfg_q.cross_connect_mode <= 1'b1;
			cfg_q.ser_time <= '0;
			cfg_q.propagation_delay <= '0;
			cfg_q.queue_slots <= 11'd1024;
			cfg_q.storage_limit <= 17'h10000;
			cfg_q.iface_a <= '0;
			cfg_q.iface_b <= 32'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_QUEUED_MODE: cfg_q.queued_mode <= cfg_data[0];
				CFG_CROSS_CONNECT: cfg_q.cross_connect_mode <= cfg_data[0];
				CFG_SER_TIME: cfg_q.ser_time <= cfg_data;
				CFG_PROP_DELAY: cfg_q.propagation_delay <= cfg_data;
				CFG_QUEUE_SLOTS: cfg_q.queue_slots <= cfg_data[SLOT_BITS-1:0];
				CFG_STORAGE_LIMIT: cfg_q.storage_limit <= cfg_data[STORE_BITS-1:0];
				CFG_IFACE_A: cfg_q.iface_a <= cfg_data;
				CFG_IFACE_B: cfg_q.iface_b <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	bqds_front #(
		.TIME_BITS(TIME_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.now(now),
		.is_lost(is_lost),
		.storage_used(storage_used),
		.rx_interface(rx_interface),
		.tx_in(tx_in),
		.item_valid(item_valid),
		.item_take(item_take),
		.item_now(item_now),
		.item_base(item_base),
		.item_cls(item_cls)
	);

	bqds_back #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.TIME_BITS(TIME_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.item_valid(item_valid),
		.item_take(item_take),
		.item_now(item_now),
		.item_base(item_base),
		.item_cls(item_cls),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.verdict(verdict),
		.tx_time(tx_time),
		.tx_interface(tx_interface),
		.queue_depth(queue_depth)
	);

endmodule

>>> tb/tb_top.sv
// Testbench for the bottleneck queue delay scheduler: arrival scoreboard, drivers and checks.
`timescale 1ns / 1ps

import bqds_pkg::*;

localparam int RING_DEPTH = 1024;

typedef struct packed {
	logic [NOW_BITS-1:0]   now;
	logic                  lost;
	logic [STORE_BITS-1:0] used;
	logic [IFACE_BITS-1:0] rx;
	logic [IFACE_BITS-1:0] txin;
} arrival_t;

typedef struct packed {
	logic [1:0]            verdict;
	logic [NOW_BITS-1:0]   tx_time;
	logic [IFACE_BITS-1:0] tx_if;
	logic [SLOT_BITS-1:0]  depth;
} decision_t;

class sched_scoreboard;
	bqds_cfg_t cfg;
	logic [NOW_BITS-1:0] ring [RING_DEPTH];
	int unsigned head, tail, count;
	logic [NOW_BITS-1:0] last_dep;
	decision_t decisions [$];
	int errors;

	function new();
		cfg.queued_mode = 1'b0;
		cfg.cross_connect_mode = 1'b1;
		cfg.ser_time = '0;
		cfg.propagation_delay = '0;
		cfg.queue_slots = 11'd1024;
		cfg.storage_limit = 17'd65536;
		cfg.iface_a = '0;
		cfg.iface_b = 32'd1;
		foreach (ring[i]) ring[i] = '0;
		head = 0;
		tail = 0;
		count = 0;
		last_dep = '0;
		errors = 0;
	endfunction

	function void set_reg(logic [IDX_BITS-1:0] idx, logic [DATA_BITS-1:0] d);
		case (idx)
		CFG_QUEUED_MODE: cfg.queued_mode = d[0];
		CFG_CROSS_CONNECT: cfg.cross_connect_mode = d[0];
		CFG_SER_TIME: cfg.ser_time = d;
		CFG_PROP_DELAY: cfg.propagation_delay = d;
		CFG_QUEUE_SLOTS: cfg.queue_slots = d[SLOT_BITS-1:0];
		CFG_STORAGE_LIMIT: cfg.storage_limit = d[STORE_BITS-1:0];
		CFG_IFACE_A: cfg.iface_a = d;
		CFG_IFACE_B: cfg.iface_b = d;
		endcase
	endfunction

	function logic [NOW_BITS-1:0] sat_add(logic [NOW_BITS-1:0] a, logic [NOW_BITS-1:0] b);
		logic [NOW_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[NOW_BITS] ? '1 : s[NOW_BITS-1:0];
	endfunction

	function void schedule_arrival(arrival_t a);
		decision_t r;
		int unsigned limit;
		logic [NOW_BITS-1:0] start;
		limit = (cfg.queue_slots < RING_DEPTH) ? int'(cfg.queue_slots) : RING_DEPTH;
		r.tx_time = sat_add(a.now, NOW_BITS'(cfg.propagation_delay));
		r.tx_if = '0;
		if (cfg.queued_mode) begin
			while (count > 0 && ring[head] <= a.now) begin
				head = (head + 1) % RING_DEPTH;
				count--;
			end
		end
		if (a.lost) begin
			r.verdict = VERDICT_LOST;
		end else if (a.used >= cfg.storage_limit || (cfg.queued_mode && count >= limit)) begin
			r.verdict = VERDICT_FULL;
		end else begin
			r.verdict = VERDICT_BUFFERED;
			if (cfg.queued_mode) begin
				start = (a.now > last_dep) ? a.now : last_dep;
				last_dep = sat_add(start, NOW_BITS'(cfg.ser_time));
				ring[tail] = last_dep;
				tail = (tail + 1) % RING_DEPTH;
				count++;
				r.tx_time = sat_add(last_dep, NOW_BITS'(cfg.propagation_delay));
			end
			if (!cfg.cross_connect_mode)
				r.tx_if = a.txin;
			else
				r.tx_if = (a.rx == cfg.iface_a) ? cfg.iface_b : cfg.iface_a;
		end
		r.depth = SLOT_BITS'(count);
		decisions.push_back(r);
	endfunction

	function void check_decision(decision_t got);
		decision_t want;
		if (decisions.size() == 0) begin
			$error("result beat with no decision pending");
			errors++;
			return;
		end
		want = decisions.pop_front();
		if (got.verdict !== want.verdict) begin
			$error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
			errors++;
		end
		if (got.tx_time !== want.tx_time) begin
			$error("tx_time: expected %0h, got %0h", want.tx_time, got.tx_time);
			errors++;
		end
		if (got.tx_if !== want.tx_if) begin
			$error("tx_interface: expected %0h, got %0h", want.tx_if, got.tx_if);
			errors++;
		end
		if (got.depth !== want.depth) begin
			$error("queue_depth: expected %0d, got %0d", want.depth, got.depth);
			errors++;
		end
	endfunction

	function int pending();
		return decisions.size();
	endfunction
endclass

module tb_top;
	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [IDX_BITS-1:0]   cfg_index;
	logic [DATA_BITS-1:0]  cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [NOW_BITS-1:0]   now;
	logic                  is_lost;
	logic [STORE_BITS-1:0] storage_used;
	logic [IFACE_BITS-1:0] rx_interface;
	logic [IFACE_BITS-1:0] tx_in;
	logic                  out_valid;
	logic                  out_stall;
	logic [1:0]            verdict;
	logic [NOW_BITS-1:0]   tx_time;
	logic [IFACE_BITS-1:0] tx_interface;
	logic [SLOT_BITS-1:0]  queue_depth;

	sched_scoreboard sb;
	int idle_mode;
	logic [NOW_BITS-1:0] t_now;

	bottleneck_queue_delay_scheduler #(
		.QUEUE_DEPTH(RING_DEPTH),
		.TIME_BITS(NOW_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.now(now),
		.is_lost(is_lost),
		.storage_used(storage_used),
		.rx_interface(rx_interface),
		.tx_in(tx_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.verdict(verdict),
		.tx_time(tx_time),
		.tx_interface(tx_interface),
		.queue_depth(queue_depth)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.schedule_arrival({now, is_lost, storage_used, rx_interface, tx_in});
		if (arst_n && out_valid && !out_stall)
			sb.check_decision({verdict, tx_time, tx_interface, queue_depth});
	end

	function automatic int draw_wait();
		case (idle_mode)
		0: return 0;
		1: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 11)) : 0;
		default: return int'($urandom_range(0, 11));
		endcase
	endfunction

	function automatic arrival_t arrival(logic [NOW_BITS-1:0] t, logic lost,
			logic [STORE_BITS-1:0] used, logic [IFACE_BITS-1:0] rx, logic [IFACE_BITS-1:0] txin);
		arrival_t a;
		a.now = t;
		a.lost = lost;
		a.used = used;
		a.rx = rx;
		a.txin = txin;
		return a;
	endfunction

	function automatic bqds_cfg_t cfg_of(logic q, logic x, logic [31:0] ser, logic [31:0] prop,
			logic [SLOT_BITS-1:0] slots, logic [STORE_BITS-1:0] store,
			logic [IFACE_BITS-1:0] a, logic [IFACE_BITS-1:0] b);
		bqds_cfg_t c;
		c.queued_mode = q;
		c.cross_connect_mode = x;
		c.ser_time = ser;
		c.propagation_delay = prop;
		c.queue_slots = slots;
		c.storage_limit = store;
		c.iface_a = a;
		c.iface_b = b;
		return c;
	endfunction

	function automatic logic [31:0] pick_ns();
		case ($urandom_range(0, 4))
		0: return '0;
		1: return $urandom_range(1, 64);
		2: return $urandom_range(1, 100000);
		3: return $urandom;
		default: return '1;
		endcase
	endfunction

	function automatic bqds_cfg_t rand_cfg();
		bqds_cfg_t c;
		c.queued_mode = ($urandom_range(0, 3) != 0);
		c.cross_connect_mode = ($urandom_range(0, 1) != 0);
		c.ser_time = pick_ns();
		c.propagation_delay = pick_ns();
		case ($urandom_range(0, 6))
		0: c.queue_slots = '0;
		1: c.queue_slots = 11'd1;
		2: c.queue_slots = SLOT_BITS'($urandom_range(2, 8));
		3: c.queue_slots = 11'd1023;
		4: c.queue_slots = 11'd1024;
		5: c.queue_slots = '1;
		default: c.queue_slots = SLOT_BITS'($urandom);
		endcase
		case ($urandom_range(0, 5))
		0: c.storage_limit = '0;
		1: c.storage_limit = 17'd1;
		2: c.storage_limit = STORE_BITS'($urandom_range(2, 64));
		3: c.storage_limit = 17'd65536;
		4: c.storage_limit = '1;
		default: c.storage_limit = STORE_BITS'($urandom);
		endcase
		c.iface_a = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 3)) : 32'($urandom);
		c.iface_b = ($urandom_range(0, 3) == 0) ? c.iface_a : 32'($urandom);
		return c;
	endfunction

	function automatic arrival_t next_arrival();
		arrival_t a;
		int r;
		logic [31:0] span;
		logic [63:0] wide;
		logic [NOW_BITS-1:0] step;
		logic [STORE_BITS-1:0] lim;
		r = $urandom_range(0, 99);
		span = sb.cfg.ser_time;
		a.lost = (r < 8);
		if (r >= 95) begin
			wide = {$urandom, $urandom};
			a.now = wide[NOW_BITS-1:0];
			if (sb.cfg.queued_mode)
				a.lost = 1'b1;
		end else if (r >= 92) begin
			a.now = (t_now > 1000) ? t_now - NOW_BITS'($urandom_range(1, 1000)) : '0;
		end else begin
			if (span == 0)
				step = NOW_BITS'($urandom_range(0, 20));
			else
				step = NOW_BITS'($urandom_range(0, span));
			if ($urandom_range(0, 3) == 0)
				step = '0;
			else if ($urandom_range(0, 3) == 0)
				step = step * 3;
			t_now = t_now + step;
			a.now = t_now;
		end
		lim = sb.cfg.storage_limit;
		r = $urandom_range(0, 19);
		if (lim == 0 || r == 0)
			a.used = STORE_BITS'($urandom);
		else if (r < 3)
			a.used = STORE_BITS'($urandom_range(lim, 17'h1FFFF));
		else
			a.used = STORE_BITS'($urandom_range(0, lim - 1));
		case ($urandom_range(0, 2))
		0: a.rx = sb.cfg.iface_a;
		1: a.rx = sb.cfg.iface_b;
		default: a.rx = $urandom;
		endcase
		a.txin = $urandom;
		return a;
	endfunction

	task automatic put_reg(input logic [IDX_BITS-1:0] idx, input logic [31:0] val, input int width);
		logic [31:0] d;
		d = $urandom;
		if (width < 32)
			d = (d & ~((32'd1 << width) - 32'd1)) | val;
		else
			d = val;
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		sb.set_reg(idx, d);
		@(posedge clk);
	endtask

	task automatic load_cfg(input bqds_cfg_t c);
		put_reg(CFG_QUEUED_MODE, 32'(c.queued_mode), 1);
		put_reg(CFG_CROSS_CONNECT, 32'(c.cross_connect_mode), 1);
		put_reg(CFG_SER_TIME, c.ser_time, 32);
		put_reg(CFG_PROP_DELAY, c.propagation_delay, 32);
		put_reg(CFG_QUEUE_SLOTS, 32'(c.queue_slots), SLOT_BITS);
		put_reg(CFG_STORAGE_LIMIT, 32'(c.storage_limit), STORE_BITS);
		put_reg(CFG_IFACE_A, c.iface_a, IFACE_BITS);
		put_reg(CFG_IFACE_B, c.iface_b, IFACE_BITS);
		cfg_we <= 1'b0;
	endtask

	task automatic send_arrival(input arrival_t a);
		int w;
		w = draw_wait();
		if (w > 0) begin
			in_valid <= 1'b0;
			repeat (w) @(posedge clk);
		end
		in_valid <= 1'b1;
		{now, is_lost, storage_used, rx_interface, tx_in} <= a;
		do @(posedge clk); while (in_stall !== 1'b0);
	endtask

	task automatic await_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	initial begin
		int w;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			w = draw_wait();
			if (w > 0) begin
				out_stall <= 1'b1;
				repeat (w) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	initial begin
		bqds_cfg_t c;
		sb = new();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_QUEUED_MODE;
		cfg_data <= '0;
		in_valid <= 1'b0;
		now <= '0;
		is_lost <= 1'b0;
		storage_used <= '0;
		rx_interface <= '0;
		tx_in <= '0;
		out_stall <= 1'b1;
		idle_mode = 1;
		t_now = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// queue fill, refusal, drain and out-of-order arrival
		load_cfg(cfg_of(1'b1, 1'b1, 32'd100, 32'd50, 11'd4, 17'd10, 32'd5, 32'd9));
		send_arrival(arrival(0, 1'b0, 0, 5, 77));
		send_arrival(arrival(0, 1'b0, 9, 7, 77));
		send_arrival(arrival(0, 1'b1, 0, 5, 77));
		send_arrival(arrival(0, 1'b0, 10, 5, 77));
		send_arrival(arrival(10, 1'b0, 0, 5, 77));
		send_arrival(arrival(10, 1'b0, 0, 5, 77));
		send_arrival(arrival(20, 1'b0, 0, 5, 77));
		send_arrival(arrival(1000, 1'b0, 0, 9, 77));
		send_arrival(arrival(1000, 1'b0, '1, 5, 77));
		send_arrival(arrival(5, 1'b0, 0, 5, 77));
		send_arrival(arrival(2000, 1'b1, 0, 5, 77));
		send_arrival(arrival(2000, 1'b0, 0, 5, 77));
		send_arrival(arrival(2000, 1'b0, 0, 9, 77));
		await_idle();

		// unqueued, saturating sums, ring left as it was
		load_cfg(cfg_of(1'b0, 1'b0, '1, '1, '0, '1, '1, '0));
		send_arrival(arrival('1, 1'b0, 0, 1, '1));
		send_arrival(arrival(48'h0000_FFFF_0000, 1'b0, '1, 0, 0));
		send_arrival(arrival(3, 1'b1, 0, 0, 0));
		send_arrival(arrival(0, 1'b0, 1, '1, 32'h5A5A_A5A5));
		await_idle();

		// no queue slots, then no storage
		load_cfg(cfg_of(1'b1, 1'b1, '0, '0, '0, 17'd65536, 32'd0, 32'd1));
		send_arrival(arrival(0, 1'b0, 0, 0, 0));
		send_arrival(arrival(0, 1'b0, 0, 1, 0));
		await_idle();
		load_cfg(cfg_of(1'b1, 1'b1, '0, '0, 11'd1024, '0, 32'd0, 32'd1));
		send_arrival(arrival(2100, 1'b0, 0, 0, 0));
		send_arrival(arrival(3000, 1'b0, 0, 1, 0));
		await_idle();

		t_now = 48'd4000;
		for (int ph = 0; ph < 6; ph++) begin
			load_cfg(rand_cfg());
			for (int k = 0; k < 100; k++) begin
				if (k % 40 == 0)
					idle_mode = $urandom_range(0, 2);
				send_arrival(next_arrival());
			end
			await_idle();
		end

		// fill the whole ring, then drain it in one arrival
		load_cfg(cfg_of(1'b1, 1'b0, '1, '1, '1, '1, '1, 32'hFFFF_FFFE));
		for (int k = 0; k < 1030; k++) begin
			if (k % 40 == 0)
				idle_mode = $urandom_range(0, 2);
			t_now = t_now + NOW_BITS'($urandom_range(0, 1000));
			send_arrival(arrival(t_now, 1'b0, STORE_BITS'($urandom_range(0, 65535)),
				$urandom, $urandom));
		end
		send_arrival(arrival('1, 1'b1, 0, 0, 0));
		await_idle();

		c = rand_cfg();
		c.propagation_delay = '1;
		load_cfg(c);
		t_now = 48'hFFFF_0000_0000;
		for (int k = 0; k < 40; k++)
			send_arrival(next_arrival());
		await_idle();

		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end
endmodule
